FILE: rtl/fbc_pkg.sv
// Shared types, constants, key rotation and round function of the 64-bit Feistel cipher.
`default_nettype none
package fbc_pkg;

  localparam int KEY_W      = 64;
  localparam int HALF_W     = 32;
  localparam int RC_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CELL_W     = 2;
  localparam int N_CELLS    = KEY_W / CELL_W;
  localparam int CELL_IDX_W = $clog2(N_CELLS);
  localparam logic [RC_W-1:0] MAX_ROUNDS = RC_W'(64);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = CFG_IDX_W'(1);

  localparam logic [KEY_W-1:0] CIPHER_KEY_RST  = '0;
  localparam logic [RC_W-1:0]  ROUND_COUNT_RST = RC_W'(16);

  // Direction codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Control shared by every key cell
  typedef struct packed {
    logic                load;
    logic                shift;
    logic                dir;
  } key_ctl_t;

  // Rotate the key left by two bits per step count
  function automatic logic [KEY_W-1:0] rotl_steps(input logic [KEY_W-1:0] key,
                                                  input logic [CELL_IDX_W-1:0] steps);
    logic [2*KEY_W-1:0] dbl;
    dbl = {key, key} << {steps, 1'b0};
    return dbl[2*KEY_W-1:KEY_W];
  endfunction

  // Byte mixing round function
  function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] x,
                                                 input logic [HALF_W-1:0] k);
    logic [HALF_W-1:0] t;
    t = x ^ k;
    return {t[23:16] ^ t[31:24], t[15:8] ^ t[31:24],
            t[23:16] ^ t[31:24], t[7:0] ^ t[31:24]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fbc_if.sv
// Valid/ready channel interfaces for blocks in and results out.
`default_nettype none
interface fbc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [fbc_pkg::HALF_W-1:0] left_half;
  logic [fbc_pkg::HALF_W-1:0] right_half;

  modport source (output valid, output op, output left_half, output right_half,
                  input ready);
  modport sink   (input valid, input op, input left_half, input right_half,
                  output ready);
endinterface

interface fbc_out_if;
  logic                      valid;
  logic                      ready;
  logic [fbc_pkg::HALF_W-1:0] out_left;
  logic [fbc_pkg::HALF_W-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface
`default_nettype wire

FILE: rtl/fbc_key_cell.sv
// One two-bit cell of the rotating round-key chain.
`default_nettype none
module fbc_key_cell (
  input  wire logic                        clk,
  input  wire fbc_pkg::key_ctl_t           ctl,
  input  wire logic [fbc_pkg::CELL_W-1:0]  load_bits,
  input  wire logic [fbc_pkg::CELL_W-1:0]  from_lower,
  input  wire logic [fbc_pkg::CELL_W-1:0]  from_upper,
  output logic      [fbc_pkg::CELL_W-1:0]  bits
);

  // Load a new key slice, or take the neighbor's slice to rotate
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bits <= load_bits;
    end else if (ctl.shift) begin
      bits <= (ctl.dir == fbc_pkg::OP_DECRYPT) ? from_upper : from_lower;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fbc_round.sv
// One Feistel round in either direction.
`default_nettype none
module fbc_round (
  input  wire logic                        op,
  input  wire logic [fbc_pkg::HALF_W-1:0]  l,
  input  wire logic [fbc_pkg::HALF_W-1:0]  r,
  input  wire logic [fbc_pkg::HALF_W-1:0]  k,
  output logic      [fbc_pkg::HALF_W-1:0]  l_next,
  output logic      [fbc_pkg::HALF_W-1:0]  r_next
);

  // Encrypt mixes the left half into the right, decrypt undoes it
  always_comb begin
    if (op == fbc_pkg::OP_DECRYPT) begin
      l_next = r;
      r_next = l ^ fbc_pkg::round_fn(r, k);
    end else begin
      l_next = r ^ fbc_pkg::round_fn(l, k);
      r_next = l;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/feistel_block_cipher_64.sv
// A block is accepted, runs n rounds (n = min(round_count, 64)) and is written to the result
// register once that is free; the next block is accepted only after that write.
// One round per cycle, set by the single round unit and the two-bit rotation of the key chain.
// The result register frees the input side: a new block is taken while a result waits.
// Reset (rst, synchronous): idle, no result, cipher_key = 0, round_count = 16.
`default_nettype none
module feistel_block_cipher_64 (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fbc_pkg::KEY_W-1:0]        cfg_data,
  fbc_in_if.sink                                in_ch,
  fbc_out_if.source                             out_ch
);

  logic [fbc_pkg::KEY_W-1:0]  cipher_key;
  logic [fbc_pkg::RC_W-1:0]   round_count;
  logic [fbc_pkg::RC_W-1:0]   rounds_eff;
  logic [fbc_pkg::RC_W-1:0]   remaining;
  logic                       op_reg;
  logic [fbc_pkg::HALF_W-1:0] l_reg;
  logic [fbc_pkg::HALF_W-1:0] r_reg;
  logic [fbc_pkg::HALF_W-1:0] l_next;
  logic [fbc_pkg::HALF_W-1:0] r_next;
  logic [fbc_pkg::KEY_W-1:0]  key_load;
  logic [fbc_pkg::KEY_W-1:0]  key_bits;
  logic [fbc_pkg::RC_W-1:0]   last_round;
  fbc_pkg::state_t            state;
  fbc_pkg::state_t            state_next;
  fbc_pkg::key_ctl_t          key_ctl;
  logic                       in_take;
  logic                       do_round;
  logic                       finish;
  logic                       out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key  <= fbc_pkg::CIPHER_KEY_RST;
      round_count <= fbc_pkg::ROUND_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fbc_pkg::REG_CIPHER_KEY:  cipher_key  <= cfg_data;
        fbc_pkg::REG_ROUND_COUNT: round_count <= cfg_data[fbc_pkg::RC_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the round count; decrypt starts from the last round key
  assign rounds_eff = (round_count > fbc_pkg::MAX_ROUNDS) ? fbc_pkg::MAX_ROUNDS
                                                           : round_count;
  assign last_round = rounds_eff - fbc_pkg::RC_W'(1);
  assign key_load = (in_ch.op == fbc_pkg::OP_DECRYPT && rounds_eff != '0)
                    ? fbc_pkg::rotl_steps(cipher_key, last_round[fbc_pkg::CELL_IDX_W-1:0])
                    : cipher_key;

  assign out_free = !out_ch.valid || out_ch.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fbc_pkg::ST_IDLE: if (in_ch.valid) state_next = fbc_pkg::ST_RUN;
      fbc_pkg::ST_RUN:  if (remaining == '0 && out_free) state_next = fbc_pkg::ST_IDLE;
      default:          state_next = fbc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_take  = 1'b0;
    do_round = 1'b0;
    finish   = 1'b0;
    case (state)
      fbc_pkg::ST_IDLE: in_take = in_ch.valid;
      fbc_pkg::ST_RUN: begin
        do_round = (remaining != '0);
        finish   = (remaining == '0) && out_free;
      end
      default: ;
    endcase
  end

  assign in_ch.ready   = (state == fbc_pkg::ST_IDLE);
  assign key_ctl.load  = in_take;
  assign key_ctl.shift = do_round;
  assign key_ctl.dir   = op_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Block halves and round counter
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_reg    <= in_ch.op;
      l_reg     <= in_ch.left_half;
      r_reg     <= in_ch.right_half;
      remaining <= rounds_eff;
    end else if (do_round) begin
      l_reg     <= l_next;
      r_reg     <= r_next;
      remaining <= remaining - fbc_pkg::RC_W'(1);
    end
  end

  // Chain of key cells, rotating two bits per round
  for (genvar i = 0; i < fbc_pkg::N_CELLS; i++) begin : g_cell
    localparam int LO = (i + fbc_pkg::N_CELLS - 1) % fbc_pkg::N_CELLS;
    localparam int HI = (i + 1) % fbc_pkg::N_CELLS;
    fbc_key_cell u_cell (
      .clk        (clk),
      .ctl        (key_ctl),
      .load_bits  (key_load[i*fbc_pkg::CELL_W +: fbc_pkg::CELL_W]),
      .from_lower (key_bits[LO*fbc_pkg::CELL_W +: fbc_pkg::CELL_W]),
      .from_upper (key_bits[HI*fbc_pkg::CELL_W +: fbc_pkg::CELL_W]),
      .bits       (key_bits[i*fbc_pkg::CELL_W +: fbc_pkg::CELL_W])
    );
  end

  fbc_round u_round (
    .op     (op_reg),
    .l      (l_reg),
    .r      (r_reg),
    .k      (key_bits[fbc_pkg::HALF_W-1:0]),
    .l_next (l_next),
    .r_next (r_next)
  );

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (finish) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_ch.out_left  <= l_reg;
      out_ch.out_right <= r_reg;
    end
  end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the 64-bit Feistel cipher: predicts every block and checks each result.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned PHASES        = 16;
  localparam int unsigned WORDS_PER_PHASE = 106;
  localparam int unsigned TAIL_CYCLES   = 72;

  // Indexes past the register list, written only to check that they are ignored
  localparam logic [fbc_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = fbc_pkg::CFG_IDX_W'(2);
  localparam logic [fbc_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = fbc_pkg::CFG_IDX_W'(3);

  typedef enum int {
    FLOW_FREE,
    SENDER_SLOW,
    RECEIVER_SLOW,
    BOTH_SLOW
  } flow_mode_t;

  typedef struct packed {
    logic [fbc_pkg::HALF_W-1:0] left;
    logic [fbc_pkg::HALF_W-1:0] right;
  } halves_t;

  // Cipher predictor with its own copy of the key and round count
  class block_scoreboard;
    logic [fbc_pkg::KEY_W-1:0] key;
    logic [fbc_pkg::RC_W-1:0]  rounds;
    halves_t          pending_halves[$];
    int unsigned      errors;
    int unsigned      blocks_seen;
    int unsigned      results_seen;

    function new();
      key          = fbc_pkg::CIPHER_KEY_RST;
      rounds       = fbc_pkg::ROUND_COUNT_RST;
      errors       = 0;
      blocks_seen  = 0;
      results_seen = 0;
    endfunction

    function void write_register(logic [fbc_pkg::CFG_IDX_W-1:0] idx,
                                 logic [fbc_pkg::KEY_W-1:0] data);
      if (idx == fbc_pkg::REG_CIPHER_KEY) begin
        key = data;
      end else if (idx == fbc_pkg::REG_ROUND_COUNT) begin
        rounds = data[fbc_pkg::RC_W-1:0];
      end
    endfunction

    // Low half of the key turned left by two bits per round
    function logic [fbc_pkg::HALF_W-1:0] subkey(int unsigned round_idx);
      int unsigned               sh;
      logic [fbc_pkg::KEY_W-1:0] rot;
      sh  = (2 * round_idx) % fbc_pkg::KEY_W;
      rot = key;
      if (sh != 0) begin
        rot = (key << sh) | (key >> (fbc_pkg::KEY_W - sh));
      end
      return rot[fbc_pkg::HALF_W-1:0];
    endfunction

    function logic [fbc_pkg::HALF_W-1:0] mix(logic [fbc_pkg::HALF_W-1:0] x,
                                             logic [fbc_pkg::HALF_W-1:0] k);
      logic [fbc_pkg::HALF_W-1:0] t;
      logic [7:0]                 b0, b1, b2, b3;
      t  = x ^ k;
      b0 = t[7:0];
      b1 = t[15:8];
      b2 = t[23:16];
      b3 = t[31:24];
      return {b2 ^ b3, b1 ^ b3, b2 ^ b3, b0 ^ b3};
    endfunction

    // Run the rounds on an accepted block and queue the halves it must produce
    function halves_t record_block(logic op, logic [fbc_pkg::HALF_W-1:0] l,
                                   logic [fbc_pkg::HALF_W-1:0] r);
      int unsigned                n;
      int unsigned                i;
      logic [fbc_pkg::HALF_W-1:0] t;
      halves_t                    res;
      n = (rounds > fbc_pkg::MAX_ROUNDS) ? int'(fbc_pkg::MAX_ROUNDS) : int'(rounds);
      if (op == fbc_pkg::OP_ENCRYPT) begin
        for (i = 0; i < n; i++) begin
          t = r ^ mix(l, subkey(i));
          r = l;
          l = t;
        end
      end else begin
        for (i = n; i > 0; i--) begin
          t = l ^ mix(r, subkey(i - 1));
          l = r;
          r = t;
        end
      end
      res.left  = l;
      res.right = r;
      pending_halves.push_back(res);
      blocks_seen++;
      return res;
    endfunction

    // Compare a result word with the oldest expected halves
    function void match_output(logic [fbc_pkg::HALF_W-1:0] l, logic [fbc_pkg::HALF_W-1:0] r);
      halves_t exp;
      results_seen++;
      if (pending_halves.size() == 0) begin
        $display("%0t: result with nothing pending: out_left %h out_right %h", $time, l, r);
        errors++;
      end else begin
        exp = pending_halves.pop_front();
        if (l !== exp.left) begin
          $display("%0t: out_left expected %h, got %h", $time, exp.left, l);
          errors++;
        end
        if (r !== exp.right) begin
          $display("%0t: out_right expected %h, got %h", $time, exp.right, r);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return pending_halves.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fbc_pkg::KEY_W-1:0]     cfg_data = '0;
  int unsigned                   sender_idle_pct = 0;
  int unsigned                   receiver_stall_pct = 0;
  int unsigned                   cycle_count = 0;
  int unsigned                   reg_writes = 0;
  block_scoreboard               board = new();

  fbc_in_if  in_ch ();
  fbc_out_if out_ch ();

  feistel_block_cipher_64 uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive ready at the falling edge, stalling as the current mode asks
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Check every result word taken at a rising edge
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      board.match_output(out_ch.out_left, out_ch.out_right);
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached with %0d results pending", $time, board.pending());
    $display("testbench NOT OK");
    $finish;
  end

  function automatic void set_flow(flow_mode_t mode);
    case (mode)
      FLOW_FREE: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      SENDER_SLOW: begin
        sender_idle_pct    = 78;
        receiver_stall_pct = 0;
      end
      RECEIVER_SLOW: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 78;
      end
      default: begin
        sender_idle_pct    = 27;
        receiver_stall_pct = 27;
      end
    endcase
  endfunction

  // Mostly random halves, with zero, all ones and single-bit patterns mixed in
  function automatic logic [fbc_pkg::HALF_W-1:0] pick_half();
    logic [fbc_pkg::HALF_W-1:0] one_hot;
    one_hot = fbc_pkg::HALF_W'(1) << $urandom_range(fbc_pkg::HALF_W - 1);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  // Offer one block word after a random gap and hold it until taken
  task automatic send_block(input logic op, input logic [fbc_pkg::HALF_W-1:0] l,
                            input logic [fbc_pkg::HALF_W-1:0] r, output halves_t predicted);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.left_half  <= l;
    in_ch.right_half <= r;
    do @(posedge clk); while (!in_ch.ready);
    predicted = board.record_block(op, l, r);
  endtask

  // Encrypt, decrypt the ciphertext back, then decrypt the plain halves
  task automatic send_triple(input logic [fbc_pkg::HALF_W-1:0] l,
                             input logic [fbc_pkg::HALF_W-1:0] r);
    halves_t ct;
    halves_t dummy;
    send_block(fbc_pkg::OP_ENCRYPT, l, r, ct);
    send_block(fbc_pkg::OP_DECRYPT, ct.left, ct.right, dummy);
    send_block(fbc_pkg::OP_DECRYPT, l, r, dummy);
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbc_pkg::KEY_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_register(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Write a round count with junk in the bits above the register
  task automatic write_rounds(input logic [fbc_pkg::RC_W-1:0] value);
    logic [fbc_pkg::KEY_W-1:0] data;
    data                    = {$urandom, $urandom};
    data[fbc_pkg::RC_W-1:0] = value;
    write_reg(fbc_pkg::REG_ROUND_COUNT, data);
  endtask

  initial begin
    int unsigned               phase;
    int unsigned               sent;
    logic [fbc_pkg::KEY_W-1:0] key;
    logic                      op;
    halves_t                   ct;
    halves_t                   pt;

    in_ch.valid      = 1'b0;
    in_ch.op         = fbc_pkg::OP_ENCRYPT;
    in_ch.left_half  = '0;
    in_ch.right_half = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, then pass-through, one round, full and saturated counts
    set_flow(FLOW_FREE);
    send_triple('0, '0);
    drain();
    write_reg(fbc_pkg::REG_CIPHER_KEY, '1);
    write_rounds(fbc_pkg::RC_W'(0));
    send_triple('1, '1);
    drain();
    write_reg(fbc_pkg::REG_CIPHER_KEY, {32'hA5A5A5A5, 32'h5A5A5A5A});
    write_rounds(fbc_pkg::RC_W'(1));
    send_triple(32'hAAAAAAAA, 32'h55555555);
    drain();
    write_reg(fbc_pkg::REG_CIPHER_KEY, '1);
    write_rounds(fbc_pkg::MAX_ROUNDS);
    send_triple('0, '1);
    drain();
    write_rounds('1);
    send_triple('1, '0);
    drain();
    write_reg(fbc_pkg::REG_CIPHER_KEY, {$urandom, $urandom});
    write_rounds(fbc_pkg::MAX_ROUNDS + fbc_pkg::RC_W'(1));
    send_triple($urandom, $urandom);
    drain();
    write_reg(REG_UNUSED_2, '0);
    write_reg(REG_UNUSED_3, '0);
    send_triple(32'h80000000, 32'h00000001);

    // Random phases over key and round count settings and flow mixes
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase % 5)
        0:       key = '0;
        1:       key = '1;
        default: key = {$urandom, $urandom};
      endcase
      write_reg(fbc_pkg::REG_CIPHER_KEY, key);
      case (phase % 8)
        0:       write_rounds(fbc_pkg::ROUND_COUNT_RST);
        1:       write_rounds(fbc_pkg::RC_W'(0));
        2:       write_rounds(fbc_pkg::RC_W'(1));
        3:       write_rounds(fbc_pkg::MAX_ROUNDS);
        4:       write_rounds('1);
        5:       write_rounds(fbc_pkg::RC_W'($urandom_range(65, 126)));
        default: write_rounds(fbc_pkg::RC_W'($urandom_range(2, 24)));
      endcase
      if (phase % 3 == 0) begin
        write_reg((phase % 2 == 0) ? REG_UNUSED_2 : REG_UNUSED_3, {$urandom, $urandom});
      end
      set_flow(flow_mode_t'(phase % 4));
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        if ($urandom_range(99) < 30) begin
          // Round trip: decrypting the ciphertext must give the plain halves back
          send_block(fbc_pkg::OP_ENCRYPT, pick_half(), pick_half(), ct);
          send_block(fbc_pkg::OP_DECRYPT, ct.left, ct.right, pt);
          sent += 2;
        end else begin
          op = ($urandom_range(1) == 0) ? fbc_pkg::OP_ENCRYPT : fbc_pkg::OP_DECRYPT;
          send_block(op, pick_half(), pick_half(), ct);
          sent += 1;
        end
      end
    end

    // Let the last results come out, then watch for strays
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.pending());
      board.errors += board.pending();
    end

    $display("Sent %0d blocks and checked %0d results over %0d register writes,",
             board.blocks_seen, board.results_seen, reg_writes);
    $display("with round counts 0 to 127, keys at both extremes and four flow mixes.");
    if (board.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/fbc_pkg.sv
rtl/fbc_if.sv
rtl/fbc_key_cell.sv
rtl/fbc_round.sv
rtl/feistel_block_cipher_64.sv
bench/testbench.sv
